// File: src/oft_pkg.sv
// Shared types, field widths and codes for the open file table.
`timescale 1ns / 1ps
`default_nettype none

package oft_pkg;

  // Default table capacity.
  localparam int unsigned DefaultEntries = 16;

  localparam int unsigned KindW    = 2;
  localparam int unsigned KeyW     = 28;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned SlotW    = 4;

  // Operation codes.
  localparam logic [KindW-1:0] KIND_OPEN  = 2'd0;
  localparam logic [KindW-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KindW-1:0] KIND_QUERY = 2'd2;

  // Access mode codes.
  localparam logic [ModeW-1:0] MODE_READ    = 2'd0;
  localparam logic [ModeW-1:0] MODE_WRITE   = 2'd1;
  localparam logic [ModeW-1:0] MODE_RW      = 2'd2;
  localparam logic [ModeW-1:0] MODE_INVALID = 2'd3;

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK           = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_MODE     = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND    = 3'd2;
  localparam logic [StatusW-1:0] ST_WRONG_TYPE   = 3'd3;
  localparam logic [StatusW-1:0] ST_ALREADY_OPEN = 3'd4;
  localparam logic [StatusW-1:0] ST_FULL         = 3'd5;
  localparam logic [StatusW-1:0] ST_NO_ENTRY     = 3'd6;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  cluster;
    logic [ModeW-1:0] mode;
    logic             is_regular_file;
  } oft_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               found;
    logic [SlotW-1:0]   slot;
    logic [ModeW-1:0]   mode_out;
  } oft_result_t;

  // One table entry as held in memory.
  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [ModeW-1:0] mode;
  } oft_entry_t;

endpackage

`default_nettype wire

// File: src/open_file_table_core.sv
// Top level of the open file table: sequencer, table memory and result register.
//
// Usage: present an item on item_i with start high; it is taken at a rising
// edge where start is high and busy is low. Each item gives one result on
// result_o, marked by result_valid_o for exactly one cycle; the receiver
// cannot hold it off and must take it in that cycle.
// Timing: the table is searched one slot per cycle through its memory read
// port, from slot zero up to the matching slot, or up to the last entry on a
// miss; no slot is read when the table is empty or the cluster is zero. The
// decision then goes through the result register, and busy drops so that the
// next item can be taken in the cycle the strobe is shown.
// A successful close then moves every later entry down one slot, one per
// cycle through the same memory, keeping busy high while it runs.
// Reset clears entry count, sequencer and result strobe only; the memory holds
// stale contents that are never read, as only slots below the count are used.
`timescale 1ns / 1ps
`default_nettype none

module open_file_table_core #(
  parameter int unsigned TableEntries = oft_pkg::DefaultEntries
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire oft_pkg::oft_item_t  item_i,
  output logic                     result_valid_o,
  output oft_pkg::oft_result_t     result_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  logic                  fin;
  oft_pkg::oft_result_t  res;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  oft_pkg::oft_entry_t   mem_wdata;
  logic                  mem_re;
  logic [IdxW-1:0]       mem_raddr;
  oft_pkg::oft_entry_t   mem_rdata;

  logic                  result_valid_q;
  oft_pkg::oft_result_t  result_q;

  oft_ctrl #(
    .TableEntries (TableEntries),
    .IdxW         (IdxW),
    .CntW         (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .fin_o       (fin),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  oft_mem #(
    .Depth (TableEntries),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The result register frees the sequencer for the next item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      result_q <= res;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

`default_nettype wire

// File: src/oft_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module oft_mem #(
  parameter int unsigned Depth = oft_pkg::DefaultEntries,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire oft_pkg::oft_entry_t wdata_i,
  input  wire logic               re_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output oft_pkg::oft_entry_t     rdata_o
);

  oft_pkg::oft_entry_t mem_q [Depth];
  oft_pkg::oft_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: src/oft_ctrl.sv
// Sequencer for the open file table: scans, decides, appends and compacts.
`timescale 1ns / 1ps
`default_nettype none

module oft_ctrl #(
  parameter int unsigned TableEntries = oft_pkg::DefaultEntries,
  parameter int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1,
  parameter int unsigned CntW = $clog2(TableEntries + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire oft_pkg::oft_item_t  item_i,
  output logic                     fin_o,
  output oft_pkg::oft_result_t     res_o,
  output logic                     mem_we_o,
  output logic [IdxW-1:0]          mem_waddr_o,
  output oft_pkg::oft_entry_t      mem_wdata_o,
  output logic                     mem_re_o,
  output logic [IdxW-1:0]          mem_raddr_o,
  input  wire oft_pkg::oft_entry_t mem_rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT
  } state_e;

  state_e                         state_q, state_d;
  oft_pkg::oft_item_t             item_q, item_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           found_q, found_d;
  logic [IdxW-1:0]                hit_q, hit_d;
  logic [oft_pkg::ModeW-1:0]      hmode_q, hmode_d;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    hit_d       = hit_q;
    hmode_d     = hmode_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    fin_o       = 1'b0;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d  = item_i;
          found_d = 1'b0;
          hit_d   = '0;
          hmode_d = '0;
          idx_d   = '0;
          // Key zero is never stored, so an empty table or a zero key skips the scan.
          if ((cnt_q == '0) || (item_i.cluster == '0)) begin
            state_d = S_DECIDE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            state_d     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (mem_rdata_i.key == item_q.cluster) begin
          found_d = 1'b1;
          hit_d   = idx_q;
          hmode_d = mem_rdata_i.mode;
          state_d = S_DECIDE;
        end else if ((CntW'(idx_q) + CntW'(1)) == cnt_q) begin
          state_d = S_DECIDE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + IdxW'(1);
          idx_d       = idx_q + IdxW'(1);
        end
      end

      S_DECIDE: begin
        fin_o          = 1'b1;
        res_o.found    = found_q;
        res_o.slot     = oft_pkg::SlotW'(hit_q);
        res_o.mode_out = hmode_q;
        state_d        = S_IDLE;
        case (item_q.kind)
          oft_pkg::KIND_OPEN: begin
            if (item_q.mode == oft_pkg::MODE_INVALID) begin
              res_o.status = oft_pkg::ST_BAD_MODE;
            end else if (item_q.cluster == '0) begin
              res_o.status = oft_pkg::ST_NOT_FOUND;
            end else if (!item_q.is_regular_file) begin
              res_o.status = oft_pkg::ST_WRONG_TYPE;
            end else if (found_q) begin
              res_o.status = oft_pkg::ST_ALREADY_OPEN;
            end else if (cnt_q == CntW'(TableEntries)) begin
              res_o.status = oft_pkg::ST_FULL;
            end else begin
              res_o.status     = oft_pkg::ST_OK;
              res_o.slot       = oft_pkg::SlotW'(cnt_q[IdxW-1:0]);
              mem_we_o         = 1'b1;
              mem_waddr_o      = cnt_q[IdxW-1:0];
              mem_wdata_o.key  = item_q.cluster;
              mem_wdata_o.mode = item_q.mode;
              cnt_d            = cnt_q + CntW'(1);
            end
          end
          oft_pkg::KIND_CLOSE: begin
            if (item_q.cluster == '0) begin
              res_o.status = oft_pkg::ST_NOT_FOUND;
            end else if (!found_q) begin
              res_o.status = oft_pkg::ST_NO_ENTRY;
            end else begin
              res_o.status = oft_pkg::ST_OK;
              cnt_d        = cnt_q - CntW'(1);
              // Entries above the removed one move down, one per cycle.
              if ((CntW'(hit_q) + CntW'(1)) < cnt_q) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = hit_q + IdxW'(1);
                idx_d       = hit_q;
                state_d     = S_SHIFT;
              end
            end
          end
          default: begin
            if (item_q.cluster == '0) begin
              res_o.status = oft_pkg::ST_NOT_FOUND;
            end else if (!found_q) begin
              res_o.status = oft_pkg::ST_NO_ENTRY;
            end else begin
              res_o.status = oft_pkg::ST_OK;
            end
          end
        endcase
      end

      S_SHIFT: begin
        // Read data holds the entry from slot idx_q + 1; cnt_q is already reduced.
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
        if ((CntW'(idx_q) + CntW'(1)) < cnt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q + IdxW'(2);
          idx_d       = idx_q + IdxW'(1);
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    hit_q   <= hit_d;
    hmode_q <= hmode_d;
  end

  assign busy = (state_q != S_IDLE);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableEntries))
    else $error("entry count exceeds table capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q != S_IDLE))
    else $error("accepted item did not leave idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> ((state_q == S_DECIDE) || (state_q == S_SHIFT)))
    else $error("table write outside decide or shift");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_o && (item_q.kind == oft_pkg::KIND_OPEN) && (res_o.status == oft_pkg::ST_OK))
      |=> (cnt_q == ($past(cnt_q) + CntW'(1))))
    else $error("successful open did not grow the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cnt_q != '0))
    else $error("compaction running on an empty table");
`endif

endmodule

`default_nettype wire

// File: sim/open_file_table_core_tb.sv
// Self-checking testbench for the open file table core: directed and random items.
`timescale 1ns / 1ps

module open_file_table_core_tb;
  import oft_pkg::*;

  // The fourth kind code has no name in the package and behaves as a query.
  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned PoolSize = 24;

  // Keeps its own copy of the table and the results that it still owes.
  class oft_checker;
    logic [KeyW-1:0]  open_keys[$];
    logic [ModeW-1:0] open_modes[$];
    oft_result_t      owed_results[$];
    int unsigned      errors;

    function void take_item(oft_item_t it);
      oft_result_t r;
      int hit;
      hit = -1;
      foreach (open_keys[i]) begin
        if (hit < 0 && open_keys[i] == it.cluster) hit = i;
      end
      r = '0;
      r.found = (hit >= 0);
      if (hit >= 0) begin
        r.slot     = SlotW'(hit);
        r.mode_out = open_modes[hit];
      end
      case (it.kind)
        KIND_OPEN: begin
          if (it.mode == MODE_INVALID) r.status = ST_BAD_MODE;
          else if (it.cluster == '0) r.status = ST_NOT_FOUND;
          else if (!it.is_regular_file) r.status = ST_WRONG_TYPE;
          else if (hit >= 0) r.status = ST_ALREADY_OPEN;
          else if (open_keys.size() >= DefaultEntries) r.status = ST_FULL;
          else begin
            r.slot   = SlotW'(open_keys.size());
            r.status = ST_OK;
            open_keys.push_back(it.cluster);
            open_modes.push_back(it.mode);
          end
        end
        KIND_CLOSE: begin
          if (it.cluster == '0) r.status = ST_NOT_FOUND;
          else if (hit < 0) r.status = ST_NO_ENTRY;
          else begin
            r.status = ST_OK;
            open_keys.delete(hit);
            open_modes.delete(hit);
          end
        end
        default: begin
          if (it.cluster == '0) r.status = ST_NOT_FOUND;
          else if (hit < 0) r.status = ST_NO_ENTRY;
          else r.status = ST_OK;
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(oft_result_t got);
      oft_result_t want;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result status=%0d found=%0d slot=%0d mode=%0d",
                   $time, got.status, got.found, got.slot, got.mode_out);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.slot !== want.slot || got.mode_out !== want.mode_out) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch: expected status=%0d found=%0d slot=%0d mode=%0d,",
                    " got status=%0d found=%0d slot=%0d mode=%0d"},
                   $time, want.status, want.found, want.slot, want.mode_out,
                   got.status, got.found, got.slot, got.mode_out);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  oft_item_t   item_i;
  logic        result_valid_o;
  oft_result_t result_o;

  oft_checker       sb;
  logic [KeyW-1:0]  key_pool[PoolSize];

  open_file_table_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Outputs are read at the edge, before any update made by that edge.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  function automatic oft_item_t make_item(logic [KindW-1:0] kind, logic [KeyW-1:0] cluster,
                                          logic [ModeW-1:0] mode, logic regular);
    oft_item_t it;
    it.kind            = kind;
    it.cluster         = cluster;
    it.mode            = mode;
    it.is_regular_file = regular;
    return it;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if (sb.open_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return sb.open_keys[$urandom_range(0, sb.open_keys.size() - 1)];
    return key_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  // Mostly well-formed opens, closes and queries on a small key pool, with some noise.
  function automatic oft_item_t random_item(int unsigned open_pct);
    oft_item_t it;
    if ($urandom_range(0, 99) < 15) begin
      it.kind            = KindW'($urandom_range(0, 3));
      it.mode            = ModeW'($urandom_range(0, 3));
      it.is_regular_file = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0:       it.cluster = '0;
        1:       it.cluster = pick_key();
        default: it.cluster = KeyW'($urandom);
      endcase
      return it;
    end
    it.mode            = ModeW'($urandom_range(MODE_READ, MODE_RW));
    it.is_regular_file = 1'b1;
    if ($urandom_range(0, 99) < open_pct) begin
      it.kind    = KIND_OPEN;
      it.cluster = key_pool[$urandom_range(0, PoolSize - 1)];
    end else if ($urandom_range(0, 1) == 0) begin
      it.kind    = KIND_CLOSE;
      it.cluster = pick_key();
    end else begin
      it.kind    = ($urandom_range(0, 3) == 0) ? KIND_SPARE : KIND_QUERY;
      it.cluster = pick_key();
    end
    return it;
  endfunction

  // Called at a clock edge; returns at the edge that accepts the item.
  task automatic send_item(oft_item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.take_item(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.owed_results.size() != 0);
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle_pct);
    int unsigned open_pct;
    open_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      // Shift the balance now and then so that the table both fills and empties.
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       open_pct = 30;
          1:       open_pct = 55;
          default: open_pct = 80;
        endcase
      end
      send_item(random_item(open_pct));
      // Each cycle in which the sender could offer an item, it holds back with idle_pct odds.
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int unsigned wait_cycles;
    sb     = new();
    start  = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    key_pool[0] = 28'd1;
    key_pool[1] = 28'hFFF_FFFF;
    key_pool[2] = 28'h800_0000;
    for (int i = 3; i < PoolSize; i++) key_pool[i] = KeyW'($urandom_range(1, 32'h0FFF_FFFF));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: check order of an open, a full table, and shifting on close.
    send_item(make_item(KIND_QUERY, key_pool[0], MODE_READ, 1'b1));
    send_item(make_item(KIND_OPEN, '0, MODE_INVALID, 1'b0));
    send_item(make_item(KIND_OPEN, '0, MODE_READ, 1'b0));
    send_item(make_item(KIND_OPEN, key_pool[0], MODE_RW, 1'b0));
    for (int i = 0; i < DefaultEntries; i++)
      send_item(make_item(KIND_OPEN, key_pool[i], ModeW'(i % 3), 1'b1));
    send_item(make_item(KIND_OPEN, key_pool[DefaultEntries], MODE_WRITE, 1'b1));
    send_item(make_item(KIND_OPEN, key_pool[0], MODE_RW, 1'b1));
    send_item(make_item(KIND_SPARE, key_pool[1], MODE_READ, 1'b0));
    send_item(make_item(KIND_CLOSE, '0, MODE_READ, 1'b1));
    send_item(make_item(KIND_CLOSE, key_pool[0], MODE_READ, 1'b1));
    send_item(make_item(KIND_QUERY, key_pool[DefaultEntries - 1], MODE_INVALID, 1'b0));
    send_item(make_item(KIND_CLOSE, key_pool[0], MODE_READ, 1'b1));
    drain();

    run_phase(470, 23);
    drain();
    run_phase(470, 58);
    drain();
    run_phase(460, 0);

    start <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk_i);
      wait_cycles++;
    end while (sb.owed_results.size() != 0 && wait_cycles < 2000);
    // A trailing close may still be moving entries down.
    repeat (40) @(posedge clk_i);
    if (sb.owed_results.size() != 0) begin
      $display("%0d expected results never arrived", sb.owed_results.size());
      sb.errors += sb.owed_results.size();
    end
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
